[rtl/exr_pkg.sv]
// Shared constants for the Euler XYZ vector rotator.
// Holds CORDIC constants, pipeline latencies and the arctangent table.
// No dependencies.
package exr_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int PIPE_LAT     = CORDIC_LAT + 6;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

    function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/exr_cordic.sv]
// Pipelined rotation-mode CORDIC: one binary angle in, cosine and sine in Q.28 out.
// One iteration per register stage. Depends on exr_pkg.
module exr_cordic
    import exr_pkg::*;
(
    input  logic               clk,
    input  logic signed [15:0] angle,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    logic signed [31:0] x_reg [0:CORDIC_STEPS];
    logic signed [31:0] y_reg [0:CORDIC_STEPS];
    logic signed [31:0] z_reg [0:CORDIC_STEPS];
    logic               flip_reg [0:CORDIC_STEPS];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic               flip_next;

    assign flip_next = angle[15] ^ angle[14];

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= {angle[15] ^ flip_next, angle[14:0], 16'b0};
        flip_reg[0] <= flip_next;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][31])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
            end
            flip_reg[i+1] <= flip_reg[i];
        end
        cos_reg <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        sin_reg <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

[rtl/euler_xyz_vector_rotate_unit.sv]
// Euler XYZ vector rotator top level: three CORDIC lanes and a six-stage MAC pipeline.
// Depends on exr_pkg and exr_cordic.
//
//  channel   handshake          words
//  input     start (busy = 0)   vec_x vec_y vec_z angle_x angle_y angle_z
//  output    done strobe        out_x out_y out_z saturated
//
// One word enters every cycle; done and out_x/out_y/out_z/saturated are registered
// at the same edge, so the result is valid while done is high.
// Latency is set by the 24-step CORDIC pipeline plus three multiply/sum stage pairs.
// Reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall, so busy stays low and nothing is ever held.
module euler_xyz_vector_rotate_unit
    import exr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               saturated
);

    localparam int IW = 34;
    localparam int PW = 66;
    localparam int SW = 68;
    localparam logic signed [SW-1:0] ROUND = SW'(1) <<< 27;

    function automatic logic signed [IW-1:0] rnd(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = (s + ROUND) >>> 28;
        return t[IW-1:0];
    endfunction

    logic signed [31:0] cx, sx, cy, sy, cz, sz;

    exr_cordic u_cx (.clk(clk), .angle(angle_x), .cos_val(cx), .sin_val(sx));
    exr_cordic u_cy (.clk(clk), .angle(angle_y), .cos_val(cy), .sin_val(sy));
    exr_cordic u_cz (.clk(clk), .angle(angle_z), .cos_val(cz), .sin_val(sz));

    logic               vld_reg [0:CORDIC_LAT-1];
    logic signed [31:0] vx_reg  [0:CORDIC_LAT-1];
    logic signed [31:0] vy_reg  [0:CORDIC_LAT-1];
    logic signed [31:0] vz_reg  [0:CORDIC_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CORDIC_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int k = 1; k < CORDIC_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg[0] <= vec_x;
        vy_reg[0] <= vec_y;
        vz_reg[0] <= vec_z;
        for (int k = 1; k < CORDIC_LAT; k++)
        begin
            vx_reg[k] <= vx_reg[k-1];
            vy_reg[k] <= vy_reg[k-1];
            vz_reg[k] <= vz_reg[k-1];
        end
    end

    logic [5:0] v_reg;
    logic signed [PW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [PW-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [PW-1:0] a3_reg, b3_reg, c3_reg, d3_reg;
    logic signed [31:0]   x_m1_reg, x_s1_reg;
    logic signed [31:0]   cy_m1_reg, sy_m1_reg, cy_s1_reg, sy_s1_reg;
    logic signed [31:0]   cz_m1_reg, sz_m1_reg, cz_s1_reg, sz_s1_reg;
    logic signed [31:0]   cz_m2_reg, sz_m2_reg, cz_s2_reg, sz_s2_reg;
    logic signed [IW-1:0] y1_reg, z1_reg, y1_m2_reg, y1_s2_reg;
    logic signed [IW-1:0] x2_reg, z2_reg, z2_m3_reg;
    logic signed [IW-1:0] x3_next, y3_next;
    logic signed [31:0]   ox_next, oy_next, oz_next;
    logic                 sat_reg, sx_f, sy_f, sz_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], vld_reg[CORDIC_LAT-1]};
    end

    always_ff @(posedge clk)
    begin
        a1_reg    <= PW'(vy_reg[CORDIC_LAT-1] * cx);
        b1_reg    <= PW'(vz_reg[CORDIC_LAT-1] * sx);
        c1_reg    <= PW'(vy_reg[CORDIC_LAT-1] * sx);
        d1_reg    <= PW'(vz_reg[CORDIC_LAT-1] * cx);
        x_m1_reg  <= vx_reg[CORDIC_LAT-1];
        cy_m1_reg <= cy;
        sy_m1_reg <= sy;
        cz_m1_reg <= cz;
        sz_m1_reg <= sz;

        y1_reg    <= rnd(SW'(a1_reg) + SW'(b1_reg));
        z1_reg    <= rnd(SW'(d1_reg) - SW'(c1_reg));
        x_s1_reg  <= x_m1_reg;
        cy_s1_reg <= cy_m1_reg;
        sy_s1_reg <= sy_m1_reg;
        cz_s1_reg <= cz_m1_reg;
        sz_s1_reg <= sz_m1_reg;

        a2_reg    <= PW'(x_s1_reg * cy_s1_reg);
        b2_reg    <= PW'(z1_reg * sy_s1_reg);
        c2_reg    <= PW'(x_s1_reg * sy_s1_reg);
        d2_reg    <= PW'(z1_reg * cy_s1_reg);
        y1_m2_reg <= y1_reg;
        cz_m2_reg <= cz_s1_reg;
        sz_m2_reg <= sz_s1_reg;

        x2_reg    <= rnd(SW'(a2_reg) - SW'(b2_reg));
        z2_reg    <= rnd(SW'(c2_reg) + SW'(d2_reg));
        y1_s2_reg <= y1_m2_reg;
        cz_s2_reg <= cz_m2_reg;
        sz_s2_reg <= sz_m2_reg;

        a3_reg    <= PW'(x2_reg * cz_s2_reg);
        b3_reg    <= PW'(y1_s2_reg * sz_s2_reg);
        c3_reg    <= PW'(x2_reg * sz_s2_reg);
        d3_reg    <= PW'(y1_s2_reg * cz_s2_reg);
        z2_m3_reg <= z2_reg;
    end

    assign x3_next = rnd(SW'(a3_reg) + SW'(b3_reg));
    assign y3_next = rnd(SW'(d3_reg) - SW'(c3_reg));

    function automatic logic [32:0] sat32(input logic signed [IW-1:0] v);
        logic ovf;
        ovf = (v[IW-1:31] != '0) && (v[IW-1:31] != '1);
        if (!ovf)
            return {1'b0, v[31:0]};
        else if (v[IW-1])
            return {1'b1, 32'h8000_0000};
        else
            return {1'b1, 32'h7fff_ffff};
    endfunction

    always_comb
    begin
        {sx_f, ox_next} = sat32(x3_next);
        {sy_f, oy_next} = sat32(y3_next);
        {sz_f, oz_next} = sat32(z2_m3_reg);
    end

    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;

    always_ff @(posedge clk)
    begin
        out_x_reg <= ox_next;
        out_y_reg <= oy_next;
        out_z_reg <= oz_next;
        sat_reg   <= sx_f | sy_f | sz_f;
    end

    assign busy      = 1'b0;
    assign done      = v_reg[5];
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign saturated = sat_reg;

endmodule

[rtl/exr_checker.sv]
// Port-level checks for the Euler XYZ vector rotator, bound to the top level.
// Depends on exr_pkg and euler_xyz_vector_rotate_unit.
module exr_checker
    import exr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z,
    input logic               saturated
);

    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result without start");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_x == MAXV || out_x == MINV || out_y == MAXV ||
                                 out_y == MINV || out_z == MAXV || out_z == MINV))
        else $error("saturated flag without clipped component");

endmodule

bind euler_xyz_vector_rotate_unit exr_checker u_exr_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
);
